// ===== src/rsie_pkg.sv =====
package rsie_pkg;

  localparam int NUM_REGS  = 32;
  localparam int REG_AW    = 5;
  localparam int MEM_BYTES = 131072;
  localparam int MEM_AW    = 17;
  localparam int MAX_LINES = 4096;
  localparam int LINE_W    = 13;
  localparam int TGT_W     = 12;
  localparam int XLEN      = 32;
  localparam int CFG_AW    = 2;
  localparam int CFG_DW    = 17;

  localparam logic [CFG_AW-1:0] CFG_ENTRY_LINE  = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_PROG_LENGTH = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_INIT_SP     = 2'd2;

  localparam logic [LINE_W-1:0] RST_PROG_LENGTH = 13'd4096;
  localparam logic [CFG_DW-1:0] RST_INIT_SP     = 17'd100000;

  localparam logic [XLEN-1:0] ECALL_PRINT = 32'd1;
  localparam logic [XLEN-1:0] ECALL_EXIT  = 32'd10;

  localparam logic [REG_AW-1:0] REG_ZERO = 5'd0;
  localparam logic [REG_AW-1:0] REG_RA   = 5'd1;
  localparam logic [REG_AW-1:0] REG_SP   = 5'd2;
  localparam logic [REG_AW-1:0] REG_A0   = 5'd10;
  localparam logic [REG_AW-1:0] REG_A1   = 5'd11;

  typedef enum logic [4:0] {
    OP_LI = 5'd0, OP_ADD = 5'd1, OP_ADDI = 5'd2, OP_MUL = 5'd3, OP_MULI = 5'd4,
    OP_SUB = 5'd5, OP_SUBI = 5'd6, OP_DIV = 5'd7, OP_DIVI = 5'd8, OP_SW = 5'd9,
    OP_SH = 5'd10, OP_SB = 5'd11, OP_LW = 5'd12, OP_LH = 5'd13, OP_LB = 5'd14,
    OP_J = 5'd15, OP_JAL = 5'd16, OP_JALR = 5'd17, OP_JR = 5'd18, OP_RET = 5'd19,
    OP_MV = 5'd20, OP_BEQ = 5'd21, OP_BNE = 5'd22, OP_BLT = 5'd23, OP_BGE = 5'd24,
    OP_BGT = 5'd25, OP_BLE = 5'd26, OP_ECALL = 5'd27, OP_RSV28 = 5'd28,
    OP_RSV29 = 5'd29, OP_RSV30 = 5'd30, OP_RSV31 = 5'd31
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RDA, ST_RDB, ST_EXEC, ST_DIV, ST_MEM, ST_LOAD, ST_WB, ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic       capture;
    logic       rd_a;
    logic       rd_b;
    logic       exec;
    logic       div_start;
    logic       mem_step;
    logic       load_step;
    logic       writeback;
    logic       finish;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic       is_halted;
    logic       past_end;
    logic       is_div;
    logic       div_zero;
    logic       div_done;
    logic       is_mem;
    logic       is_load;
    logic       mem_last;
  } sts_t;

endpackage

// ===== src/riscv_subset_instruction_executor.sv =====
// channel | words                                       | flow
// in      | cmd dest_reg src_reg_a src_reg_b immediate target_line | valid/stall
// out     | next_line print_valid print_value halted divide_fault   | valid/stall
// cfg     | cfg_index cfg_data                          | cfg_we, no wait
// One word at a time. Loads and stores move one byte at a time, and a divide
// waits on the divider (one quotient bit per cycle in the divider).
// Halted or past-end words skip execution and repeat the halting result.
// Reset loads x2 with the reset value of the stack pointer setting; memory is not cleared.
// The next input word is taken once the previous result sits in the output register.
module riscv_subset_instruction_executor (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [16:0]                 cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [4:0]                  cmd,
  input  logic [4:0]                  dest_reg,
  input  logic [4:0]                  src_reg_a,
  input  logic [4:0]                  src_reg_b,
  input  logic signed [31:0]          immediate,
  input  logic [11:0]                 target_line,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [12:0]                 next_line,
  output logic                        print_valid,
  output logic signed [31:0]          print_value,
  output logic                        halted,
  output logic                        divide_fault
);
  import rsie_pkg::*;

  ctl_t ctl;
  sts_t sts;
  logic [12:0]        r_line;
  logic               r_pv, r_halted, r_fault;
  logic signed [31:0] r_pval;

  rsie_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_busy(out_valid && out_stall), .sts(sts), .ctl(ctl)
  );

  rsie_dp u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .sts(sts),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd), .dest_reg(dest_reg), .src_reg_a(src_reg_a), .src_reg_b(src_reg_b),
    .immediate(immediate), .target_line(target_line),
    .res_line(r_line), .res_pv(r_pv), .res_pval(r_pval),
    .res_halted(r_halted), .res_fault(r_fault)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (ctl.finish) begin
      next_line    <= r_line;
      print_valid  <= r_pv;
      print_value  <= r_pval;
      halted       <= r_halted;
      divide_fault <= r_fault;
    end
  end
endmodule

// ===== src/rsie_ram.sv =====
module rsie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== src/rsie_div.sv =====
module rsie_div (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [rsie_pkg::XLEN-1:0] num,
  input  logic [rsie_pkg::XLEN-1:0] den,
  output logic                    done,
  output logic [rsie_pkg::XLEN-1:0] quo
);
  import rsie_pkg::*;

  logic [XLEN-1:0] rem, q, d;
  logic [5:0]      cnt;
  logic            busy, neg;
  logic [XLEN:0]   trial;
  logic [XLEN-1:0] rem_sh;

  assign rem_sh = {rem[XLEN-2:0], q[XLEN-1]};
  assign trial  = {1'b0, rem_sh} - {1'b0, d};
  assign quo    = neg ? (XLEN'(0) - q) : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 6'd31) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
    if (start) begin
      rem <= '0;
      q   <= num[XLEN-1] ? (XLEN'(0) - num) : num;
      d   <= den[XLEN-1] ? (XLEN'(0) - den) : den;
      neg <= num[XLEN-1] ^ den[XLEN-1];
      cnt <= '0;
    end else if (busy) begin
      cnt <= cnt + 6'd1;
      if (!trial[XLEN]) begin
        rem <= trial[XLEN-1:0];
        q   <= {q[XLEN-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        q   <= {q[XLEN-2:0], 1'b0};
      end
    end
  end
endmodule

// ===== src/rsie_ctrl.sv =====
module rsie_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             out_busy,
  input  rsie_pkg::sts_t   sts,
  output rsie_pkg::ctl_t   ctl
);
  import rsie_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_next  = ST_RDA;
        end
      end
      ST_RDA: begin
        ctl.rd_a = 1'b1;
        if (sts.is_halted || sts.past_end) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_RDB;
        end
      end
      ST_RDB: begin
        ctl.rd_b   = 1'b1;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        ctl.exec = 1'b1;
        if (sts.is_div && !sts.div_zero) begin
          ctl.div_start = 1'b1;
          state_next    = ST_DIV;
        end else if (sts.is_mem) begin
          state_next = ST_MEM;
        end else begin
          state_next = ST_WB;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_next = ST_WB;
        end
      end
      ST_MEM: begin
        ctl.mem_step = 1'b1;
        if (sts.is_load) begin
          state_next = ST_LOAD;
        end else if (sts.mem_last) begin
          state_next = ST_WB;
        end
      end
      ST_LOAD: begin
        ctl.load_step = 1'b1;
        state_next    = sts.mem_last ? ST_WB : ST_MEM;
      end
      ST_WB: begin
        ctl.writeback = 1'b1;
        state_next    = ST_DONE;
      end
      ST_DONE: begin
        if (!out_busy) begin
          ctl.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// ===== src/rsie_dp.sv =====
module rsie_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  rsie_pkg::ctl_t               ctl,
  output rsie_pkg::sts_t               sts,
  input  logic                         cfg_we,
  input  logic [rsie_pkg::CFG_AW-1:0]  cfg_index,
  input  logic [rsie_pkg::CFG_DW-1:0]  cfg_data,
  input  logic [4:0]                   cmd,
  input  logic [4:0]                   dest_reg,
  input  logic [4:0]                   src_reg_a,
  input  logic [4:0]                   src_reg_b,
  input  logic signed [31:0]           immediate,
  input  logic [11:0]                  target_line,
  output logic [12:0]                  res_line,
  output logic                         res_pv,
  output logic signed [31:0]           res_pval,
  output logic                         res_halted,
  output logic                         res_fault
);
  import rsie_pkg::*;

  logic [TGT_W-1:0]  entry_line;
  logic [LINE_W-1:0] program_length;
  logic [CFG_DW-1:0] init_sp;
  logic              item_seen, halt_flag;
  logic [LINE_W-1:0] cur_line, eff_len;

  logic [XLEN-1:0]   regs [NUM_REGS];

  op_t               op;
  logic [REG_AW-1:0] rd, ra, rb;
  logic [XLEN-1:0]   imm, va, vb, ldv, wbv;
  logic [TGT_W-1:0]  tgt;
  logic              wb_en, fault, pv;
  logic [XLEN-1:0]   pval;
  logic [LINE_W:0]   chosen;
  logic              stop;
  logic [1:0]        bidx, nbytes_m1;
  logic [XLEN-1:0]   addr;

  logic [MEM_AW-1:0] m_addr;
  logic              m_we;
  logic [7:0]        m_wdata, m_rdata;

  logic              div_done;
  logic [XLEN-1:0]   div_q;

  logic [XLEN-1:0]   opb;
  logic              slt_ab, slt_ba;
  logic [LINE_W:0]   nxt;

  assign eff_len = (program_length > LINE_W'(MAX_LINES)) ? LINE_W'(MAX_LINES) : program_length;

  rsie_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wdata), .rdata(m_rdata)
  );

  rsie_div u_div (
    .clk(clk), .rst(rst), .start(ctl.div_start), .num(va), .den(opb),
    .done(div_done), .quo(div_q)
  );

  assign opb    = (op == OP_ADD || op == OP_MUL || op == OP_SUB || op == OP_DIV) ? vb : imm;
  assign slt_ab = $signed(va) < $signed(vb);
  assign slt_ba = $signed(vb) < $signed(va);
  assign m_addr = MEM_AW'(addr + XLEN'(bidx));
  assign m_we   = ctl.mem_step && (op == OP_SW || op == OP_SH || op == OP_SB);
  assign m_wdata = vb[8*bidx +: 8];

  always_comb begin
    unique case (op)
      OP_SW, OP_LW: nbytes_m1 = 2'd3;
      OP_SH, OP_LH: nbytes_m1 = 2'd1;
      default:      nbytes_m1 = 2'd0;
    endcase
  end

  assign sts.is_halted = halt_flag;
  assign sts.past_end  = cur_line >= eff_len;
  assign sts.is_div    = op == OP_DIV || op == OP_DIVI;
  assign sts.div_zero  = opb == '0;
  assign sts.div_done  = div_done;
  assign sts.is_mem    = op == OP_SW || op == OP_SH || op == OP_SB ||
                         op == OP_LW || op == OP_LH || op == OP_LB;
  assign sts.is_load   = op == OP_LW || op == OP_LH || op == OP_LB;
  assign sts.mem_last  = bidx == nbytes_m1;

  assign nxt = chosen + (LINE_W+1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_line     <= '0;
      program_length <= RST_PROG_LENGTH;
      init_sp        <= RST_INIT_SP;
      item_seen      <= 1'b0;
      halt_flag      <= 1'b0;
      cur_line       <= '0;
      res_line       <= '0;
      res_pv         <= 1'b0;
      res_pval       <= '0;
      res_halted     <= 1'b0;
      res_fault      <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) begin
        regs[i] <= (i == int'(REG_SP)) ? XLEN'(RST_INIT_SP) : '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ENTRY_LINE: begin
            entry_line <= cfg_data[TGT_W-1:0];
            if (!item_seen) cur_line <= LINE_W'(cfg_data[TGT_W-1:0]);
          end
          CFG_PROG_LENGTH: program_length <= cfg_data[LINE_W-1:0];
          CFG_INIT_SP: begin
            init_sp <= cfg_data;
            if (!item_seen) regs[REG_SP] <= XLEN'(cfg_data);
          end
          default: ;
        endcase
      end
      if (ctl.capture) begin
        op  <= op_t'(cmd);
        rd  <= dest_reg;
        ra  <= src_reg_a;
        rb  <= src_reg_b;
        imm <= immediate;
        tgt <= target_line;
      end
      if (ctl.rd_a) begin
        va <= regs[ra];
        wb_en <= 1'b0;
        fault <= 1'b0;
        pv    <= 1'b0;
        pval  <= '0;
        stop  <= 1'b0;
        bidx  <= '0;
        ldv   <= '0;
        chosen <= (LINE_W+1)'(cur_line);
        if (!halt_flag) begin
          item_seen <= 1'b1;
          if (cur_line >= eff_len) begin
            halt_flag  <= 1'b1;
            res_line   <= eff_len;
            res_pv     <= 1'b0;
            res_pval   <= '0;
            res_halted <= 1'b1;
            res_fault  <= 1'b0;
          end
        end
      end
      if (ctl.rd_b) begin
        vb <= (op == OP_SW || op == OP_SH || op == OP_SB) ? regs[rd] : regs[rb];
        if (op == OP_RET) va <= regs[REG_RA];
      end
      if (ctl.exec) begin
        addr <= va + imm;
        unique case (op)
          OP_LI:  begin wbv <= imm;        wb_en <= 1'b1; end
          OP_ADD, OP_ADDI: begin wbv <= va + opb; wb_en <= 1'b1; end
          OP_MUL, OP_MULI: begin wbv <= va * opb; wb_en <= 1'b1; end
          OP_SUB, OP_SUBI: begin wbv <= va - opb; wb_en <= 1'b1; end
          OP_DIV, OP_DIVI: begin
            if (opb == '0) fault <= 1'b1;
            else wb_en <= 1'b1;
          end
          OP_LW, OP_LH, OP_LB: wb_en <= 1'b1;
          OP_MV:  begin wbv <= va; wb_en <= 1'b1; end
          OP_J:   chosen <= (LINE_W+1)'(tgt);
          OP_JAL: begin
            chosen <= (LINE_W+1)'(tgt);
            wbv <= XLEN'(cur_line); rd <= REG_RA; wb_en <= 1'b1;
          end
          OP_JALR: begin
            chosen <= va[LINE_W:0];
            wbv <= XLEN'(cur_line); rd <= REG_RA; wb_en <= 1'b1;
          end
          OP_JR, OP_RET: chosen <= va[LINE_W:0];
          OP_BEQ: if (va == vb) chosen <= (LINE_W+1)'(tgt);
          OP_BNE: if (va != vb) chosen <= (LINE_W+1)'(tgt);
          OP_BLT: if (slt_ab)   chosen <= (LINE_W+1)'(tgt);
          OP_BGE: if (!slt_ab)  chosen <= (LINE_W+1)'(tgt);
          OP_BGT: if (slt_ba)   chosen <= (LINE_W+1)'(tgt);
          OP_BLE: if (!slt_ba)  chosen <= (LINE_W+1)'(tgt);
          OP_ECALL: begin
            if (regs[REG_A0] == ECALL_PRINT) begin
              pv <= 1'b1; pval <= regs[REG_A1];
            end else if (regs[REG_A0] == ECALL_EXIT) begin
              stop <= 1'b1;
            end
          end
          default: ;
        endcase
        // jump register values above the line range always end the run
        if ((op == OP_JALR || op == OP_JR || op == OP_RET) && va[XLEN-1:LINE_W] != '0) begin
          chosen <= {1'b1, {LINE_W{1'b0}}};
        end
      end
      if (div_done) wbv <= div_q;
      if (ctl.mem_step && !sts.is_load) bidx <= bidx + 2'd1;
      if (ctl.load_step) begin
        ldv[8*bidx +: 8] <= m_rdata;
        bidx <= bidx + 2'd1;
      end
      if (ctl.writeback) begin
        if (wb_en && rd != REG_ZERO) begin
          unique case (op)
            OP_LW: regs[rd] <= ldv;
            OP_LH: regs[rd] <= {{16{ldv[15]}}, ldv[15:0]};
            OP_LB: regs[rd] <= {{24{ldv[7]}}, ldv[7:0]};
            default: regs[rd] <= wbv;
          endcase
        end
        res_pv    <= pv;
        res_pval  <= pval;
        res_fault <= fault;
        if (stop) begin
          halt_flag  <= 1'b1;
          res_halted <= 1'b1;
          res_line   <= cur_line;
        end else if (nxt >= (LINE_W+1)'(eff_len)) begin
          halt_flag  <= 1'b1;
          res_halted <= 1'b1;
          cur_line   <= eff_len;
          res_line   <= eff_len;
        end else begin
          res_halted <= 1'b0;
          cur_line   <= nxt[LINE_W-1:0];
          res_line   <= nxt[LINE_W-1:0];
        end
      end
    end
  end
endmodule

// ===== tb/riscv_subset_instruction_executor_tb.sv =====
`timescale 1ns / 100ps

module riscv_subset_instruction_executor_tb;
  import rsie_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 60;

  typedef struct packed {
    logic [12:0] nl;
    logic        pv;
    logic [31:0] pval;
    logic        h;
    logic        df;
  } line_result_t;

  typedef struct {
    logic [31:0] addr;
    int          nbytes;
  } store_rec_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [4:0]  cmd = '0, dest_reg = '0, src_reg_a = '0, src_reg_b = '0;
  logic signed [31:0] immediate = '0;
  logic [11:0] target_line = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [12:0] next_line;
  logic        print_valid;
  logic signed [31:0] print_value;
  logic        halted;
  logic        divide_fault;

  riscv_subset_instruction_executor dut (.*);

  always #4 clk = ~clk;

  // predictor state
  logic [31:0] regs [NUM_REGS];
  logic [7:0]  mem_img [MEM_BYTES];
  int          cur_line;
  logic        halt_flag;
  logic        item_seen;
  line_result_t held_res;
  int          entry_cfg, len_cfg, sp_cfg;
  store_rec_t  store_log[$];
  line_result_t line_q[$];

  int err_cnt = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  function automatic int eff_len();
    return len_cfg > MAX_LINES ? MAX_LINES : len_cfg;
  endfunction

  function automatic void set_reg(logic [4:0] r, logic [31:0] v);
    if (r != REG_ZERO) regs[r] = v;
  endfunction

  function automatic logic [31:0] quotient(logic [31:0] a, logic [31:0] b);
    if (a == 32'h8000_0000 && b == 32'hffff_ffff) return a;
    return $signed(a) / $signed(b);
  endfunction

  function automatic void store_bytes(logic [31:0] addr, logic [31:0] v, int n);
    logic [31:0] a;
    store_rec_t s;
    for (int k = 0; k < n; k++) begin
      a = addr + k;
      mem_img[a[MEM_AW-1:0]] = v[8*k +: 8];
    end
    s.addr = addr;
    s.nbytes = n;
    store_log.insert(store_log.size(), s);
    if (store_log.size() > 64) void'(store_log.pop_front());
  endfunction

  function automatic logic [31:0] load_bytes(logic [31:0] addr, int n);
    logic [31:0] a, v;
    v = '0;
    for (int k = 0; k < n; k++) begin
      a = addr + k;
      v[8*k +: 8] = mem_img[a[MEM_AW-1:0]];
    end
    return v;
  endfunction

  function automatic line_result_t predict_line(op_t c, logic [4:0] rd, logic [4:0] ra,
      logic [4:0] rb, logic [31:0] imm, logic [11:0] tgt);
    line_result_t r;
    logic [31:0] va, vb, addr, chosen, w;
    logic [32:0] nxt;
    int len;
    logic stop, fault;
    r = '0;
    stop = 0;
    fault = 0;
    if (halt_flag) return held_res;
    item_seen = 1;
    len = eff_len();
    if (cur_line >= len) begin
      halt_flag = 1;
      r.nl = 13'(len);
      r.h = 1;
      held_res = r;
      return r;
    end
    va = regs[ra];
    vb = regs[rb];
    addr = va + imm;
    chosen = cur_line;
    case (c)
      OP_LI:   set_reg(rd, imm);
      OP_ADD:  set_reg(rd, va + vb);
      OP_ADDI: set_reg(rd, va + imm);
      OP_MUL:  set_reg(rd, va * vb);
      OP_MULI: set_reg(rd, va * imm);
      OP_SUB:  set_reg(rd, va - vb);
      OP_SUBI: set_reg(rd, va - imm);
      OP_DIV:  if (vb == 0) fault = 1; else set_reg(rd, quotient(va, vb));
      OP_DIVI: if (imm == 0) fault = 1; else set_reg(rd, quotient(va, imm));
      OP_SW:   store_bytes(addr, regs[rd], 4);
      OP_SH:   store_bytes(addr, regs[rd], 2);
      OP_SB:   store_bytes(addr, regs[rd], 1);
      OP_LW:   set_reg(rd, load_bytes(addr, 4));
      OP_LH: begin
        w = load_bytes(addr, 2);
        set_reg(rd, {{16{w[15]}}, w[15:0]});
      end
      OP_LB: begin
        w = load_bytes(addr, 1);
        set_reg(rd, {{24{w[7]}}, w[7:0]});
      end
      OP_J:    chosen = tgt;
      OP_JAL: begin
        set_reg(REG_RA, cur_line);
        chosen = tgt;
      end
      OP_JALR: begin
        chosen = va;
        set_reg(REG_RA, cur_line);
      end
      OP_JR:   chosen = va;
      OP_RET:  chosen = regs[REG_RA];
      OP_MV:   set_reg(rd, va);
      OP_BEQ:  if (va == vb) chosen = tgt;
      OP_BNE:  if (va != vb) chosen = tgt;
      OP_BLT:  if ($signed(va) < $signed(vb)) chosen = tgt;
      OP_BGE:  if (!($signed(va) < $signed(vb))) chosen = tgt;
      OP_BGT:  if ($signed(vb) < $signed(va)) chosen = tgt;
      OP_BLE:  if (!($signed(vb) < $signed(va))) chosen = tgt;
      OP_ECALL: begin
        if (regs[REG_A0] == ECALL_PRINT) begin
          r.pv = 1;
          r.pval = regs[REG_A1];
        end else if (regs[REG_A0] == ECALL_EXIT) begin
          stop = 1;
        end
      end
      default: ;
    endcase
    if (stop) begin
      halt_flag = 1;
    end else begin
      nxt = {1'b0, chosen} + 33'd1;
      if (nxt >= len) begin
        halt_flag = 1;
        cur_line = len;
      end else begin
        cur_line = int'(nxt);
      end
    end
    r.nl = 13'(cur_line);
    r.h = halt_flag;
    r.df = fault;
    if (halt_flag) held_res = r;
    return r;
  endfunction

  task automatic send_word(op_t c, logic [4:0] rd, logic [4:0] ra, logic [4:0] rb,
      logic [31:0] imm, logic [11:0] tgt);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    cmd <= c;
    dest_reg <= rd;
    src_reg_a <= ra;
    src_reg_b <= rb;
    immediate <= imm;
    target_line <= tgt;
    do @(posedge clk); while (in_stall);
    line_q.insert(line_q.size(), predict_line(c, rd, ra, rb, imm, tgt));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (line_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [16:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      CFG_ENTRY_LINE: begin
        entry_cfg = val[11:0];
        if (!item_seen) cur_line = entry_cfg;
      end
      CFG_PROG_LENGTH: len_cfg = val[12:0];
      CFG_INIT_SP: begin
        sp_cfg = val;
        if (!item_seen) regs[REG_SP] = sp_cfg;
      end
      default: ;
    endcase
  endtask

  // random instruction that keeps the program running
  task automatic rand_word();
    op_t c;
    logic [4:0] rd, ra, rb;
    logic [31:0] imm;
    logic [11:0] tgt;
    store_rec_t s;
    int len, k;
    len = eff_len();
    c = op_t'($urandom_range(31));
    rd = 5'($urandom);
    ra = 5'($urandom);
    rb = 5'($urandom);
    case ($urandom_range(3))
      0: imm = $urandom;
      1: imm = 32'($urandom_range(16)) - 32'd8;
      2: imm = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: imm = $urandom_range(255);
    endcase
    tgt = 12'($urandom_range(len - 2));
    if (c == OP_LI && $urandom_range(3) == 0) begin
      rd = $urandom_range(1) ? REG_A0 : REG_A1;
      imm = $urandom_range(1) ? ECALL_PRINT : $urandom;
    end
    if (c inside {OP_LW, OP_LH, OP_LB}) begin
      if (store_log.size() == 0) begin
        c = OP_SW;
      end else begin
        s = store_log[$urandom_range(store_log.size() - 1)];
        k = (c == OP_LW) ? 4 : (c == OP_LH) ? 2 : 1;
        if (k > s.nbytes) c = (s.nbytes == 4) ? OP_LW : (s.nbytes == 2) ? OP_LH : OP_LB;
        imm = s.addr - regs[ra];
      end
    end
    if (c inside {OP_JR, OP_JALR} && regs[ra] >= len - 1) ra = REG_ZERO;
    if (c == OP_RET && regs[REG_RA] >= len - 1) c = OP_JAL;
    if (c == OP_ECALL && regs[REG_A0] == ECALL_EXIT) c = OP_RSV28;
    if (cur_line >= len - 2) c = OP_J;
    send_word(c, rd, ra, rb, imm, tgt);
  endtask

  task automatic run_random(int n, int sidle, int rstall);
    idle_pct = sidle;
    stall_pct = rstall;
    repeat (n) rand_word();
    drain();
  endtask

  task automatic test_config_before_start();
    cfg_write(CFG_ENTRY_LINE, 17'd4095);
    cfg_write(CFG_PROG_LENGTH, 17'd0);
    cfg_write(CFG_INIT_SP, 17'd131071);
    cfg_write(CFG_INIT_SP, 17'd0);
    cfg_write(CFG_ENTRY_LINE, 17'($urandom_range(100)));
    cfg_write(CFG_PROG_LENGTH, 17'd4096);
    cfg_write(CFG_INIT_SP, 17'($urandom_range(131071)));
  endtask

  task automatic test_directed();
    idle_pct = 0;
    stall_pct = 0;
    send_word(OP_LI, 5'd5, 0, 0, 32'h7fff_ffff, 0);
    send_word(OP_LI, 5'd6, 0, 0, 32'h8000_0000, 0);
    send_word(OP_LI, REG_ZERO, 0, 0, 32'd123, 0);
    send_word(OP_LI, 5'd7, 0, 0, 32'hffff_ffff, 0);
    send_word(OP_ADD, 5'd8, 5'd5, 5'd7, 0, 0);
    send_word(OP_ADDI, 5'd9, 5'd6, 0, 32'hffff_ffff, 0);
    send_word(OP_MUL, 5'd12, 5'd5, 5'd5, 0, 0);
    send_word(OP_MULI, 5'd13, 5'd6, 0, 32'hffff_ffff, 0);
    send_word(OP_SUB, 5'd14, 5'd6, 5'd5, 0, 0);
    send_word(OP_SUBI, 5'd15, 5'd5, 0, 32'h8000_0000, 0);
    send_word(OP_DIV, 5'd16, 5'd6, 5'd7, 0, 0);
    send_word(OP_DIV, 5'd17, 5'd5, REG_ZERO, 0, 0);
    send_word(OP_DIVI, 5'd18, 5'd6, 0, 0, 0);
    send_word(OP_DIVI, 5'd19, 5'd14, 0, 32'hffff_fffd, 0);
    // base -1 wraps to the top of memory
    send_word(OP_SW, 5'd6, 5'd7, 0, 0, 0);
    send_word(OP_SH, 5'd5, 5'd7, 0, 32'd4, 0);
    send_word(OP_SB, 5'd14, 5'd7, 0, 32'd6, 0);
    send_word(OP_LW, 5'd21, 5'd7, 0, 0, 0);
    send_word(OP_LH, 5'd22, 5'd7, 0, 32'd4, 0);
    send_word(OP_LB, 5'd23, 5'd7, 0, 32'd1, 0);
    send_word(OP_MV, 5'd24, 5'd5, 0, 0, 0);
    send_word(OP_JAL, 0, 0, 0, 0, 12'd40);
    send_word(OP_JALR, 0, REG_RA, 0, 0, 0);
    send_word(OP_JR, 0, REG_ZERO, 0, 0, 0);
    send_word(OP_RET, 0, 0, 0, 0, 0);
    for (int b = OP_BEQ; b <= OP_BLE; b++) send_word(op_t'(b), 0, 5'd5, 5'd6, 0, 12'd60);
    send_word(OP_LI, REG_A0, 0, 0, ECALL_PRINT, 0);
    send_word(OP_MV, REG_A1, 5'd6, 0, 0, 0);
    send_word(OP_ECALL, 0, 0, 0, 0, 0);
    send_word(OP_RSV29, 5'd3, 5'd3, 5'd3, 32'hdead_beef, 12'd7);
    drain();
  endtask

  task automatic test_late_config();
    cfg_write(CFG_ENTRY_LINE, 17'd0);
    cfg_write(CFG_INIT_SP, 17'd0);
    cfg_write(CFG_PROG_LENGTH, 17'd4096);
    run_random(20, 0, 0);
  endtask

  task automatic test_short_program();
    send_word(OP_J, 0, 0, 0, 0, 12'd2);
    drain();
    cfg_write(CFG_PROG_LENGTH, 17'd64);
    run_random(60, 18, 18);
    cfg_write(CFG_PROG_LENGTH, 17'd4096);
  endtask

  task automatic test_halt();
    idle_pct = 18;
    stall_pct = 18;
    case ($urandom_range(2))
      0: begin
        send_word(OP_J, 0, 0, 0, 0, 12'd5);
        send_word(OP_LI, REG_A0, 0, 0, ECALL_EXIT, 0);
        send_word(OP_ECALL, 0, 0, 0, 0, 0);
      end
      1: send_word(OP_J, 0, 0, 0, 0, 12'd4095);
      default: begin
        drain();
        cfg_write(CFG_PROG_LENGTH, 17'($urandom_range(cur_line)));
        send_word(OP_LI, 5'd9, 0, 0, 32'd1, 0);
      end
    endcase
    repeat (6) send_word(op_t'($urandom_range(31)), 5'($urandom), 5'($urandom),
                         5'($urandom), $urandom, 12'($urandom));
    drain();
  endtask

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin : check_results
    line_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (line_q.size() == 0) begin
        $display("%0t: unexpected word next_line=%0d", $time, next_line);
        err_cnt++;
      end else begin
        e = line_q.pop_front();
        check_field("next_line", 32'(e.nl), 32'(next_line));
        check_field("print_valid", 32'(e.pv), 32'(print_valid));
        check_field("print_value", e.pval, print_value);
        check_field("halted", 32'(e.h), 32'(halted));
        check_field("divide_fault", 32'(e.df), 32'(divide_fault));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("riscv_subset_instruction_executor regression: fail");
      $finish;
    end
  end

  initial begin
    foreach (regs[i]) regs[i] = '0;
    entry_cfg = 0;
    len_cfg = RST_PROG_LENGTH;
    sp_cfg = RST_INIT_SP;
    regs[REG_SP] = sp_cfg;
    cur_line = 0;
    halt_flag = 0;
    item_seen = 0;
    held_res = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    test_config_before_start();
    test_directed();
    run_random(110, 0, 0);
    run_random(110, 50, 0);
    run_random(110, 0, 50);
    run_random(110, 18, 18);
    test_late_config();
    test_short_program();
    test_halt();
    if (err_cnt == 0) begin
      $display("riscv_subset_instruction_executor regression: pass");
    end else begin
      $display("riscv_subset_instruction_executor regression: fail");
    end
    $finish;
  end

endmodule
